[design/dcce_pkg.sv]
package dcce_pkg;

  localparam int MAX_DEVICES_DEF = 32;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 7;
  localparam int COUNT_W     = 6;
  localparam int FRAME_BYTES = 8;
  localparam int FIDX_W      = $clog2(FRAME_BYTES);
  localparam int ECHO_DEPTH  = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;

  localparam logic [BYTE_W-1:0] PEC_POLY       = 8'hB2;
  localparam logic [2:0]        ADDR_WRITE_TAG = 3'b100;
  localparam logic [2:0]        ADDR_READ_TAG  = 3'b101;
  localparam logic [LEN_W-1:0]  WRITE_RESP_LEN = 7'd6;
  localparam logic [LEN_W-1:0]  READ_BASE_LEN  = 7'd5;
  localparam logic [LEN_W-1:0]  READ_DEV_LEN   = 7'd7;
  localparam logic [LEN_W-1:0]  POS_MAX        = 7'd127;
  localparam logic [FIDX_W-1:0] WRITE_LAST_IDX = 3'd7;
  localparam logic [FIDX_W-1:0] READ_LAST_IDX  = 3'd6;

  // opcodes of an input request
  localparam logic OP_ISSUE    = 1'b0;
  localparam logic OP_RESPONSE = 1'b1;

  // command kinds
  localparam logic [1:0] KIND_WRITE_ALL = 2'd0;
  localparam logic [1:0] KIND_WRITE_DEV = 2'd1;
  localparam logic [1:0] KIND_READ_ALL  = 2'd2;
  localparam logic [1:0] KIND_READ_DEV  = 2'd3;

  // register indexes on the configuration port
  localparam logic [1:0] REG_DEVICE_COUNT = 2'd0;
  localparam logic [1:0] REG_WRITE_ALL    = 2'd1;
  localparam logic [1:0] REG_READ_ALL     = 2'd2;
  localparam logic [1:0] REG_QUEUE_LOAD   = 2'd3;

  typedef struct packed {
    logic [COUNT_W-1:0] device_count;
    logic [BYTE_W-1:0]  write_all_code;
    logic [BYTE_W-1:0]  read_all_code;
    logic [BYTE_W-1:0]  queue_load_code;
  } cfg_t;

  typedef struct packed {
    logic                                is_verdict;
    logic [FIDX_W-1:0]                   last_idx;
    logic [FRAME_BYTES-1:0][BYTE_W-1:0] frame;
    logic                                pass;
    logic                                crc_error;
    logic                                echo_error;
    logic                                alive_error;
    logic                                length_error;
  } job_t;

  // reflected CRC-8 over one byte
  function automatic logic [BYTE_W-1:0] pec_update(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ PEC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[design/daisy_chain_command_engine.sv]
// Command engine for a battery-monitor daisy chain behind a serial bridge. An issue
// request builds one frame (queue-load code, length, command or device address,
// register, data or check byte, PEC, alive seed) and sends it out one byte per cycle
// while out_ready is high: 8 bytes for writes, 7 for reads. A response request checks
// one received byte per cycle and the byte marked last yields one verdict. Response
// bytes are taken every cycle while the two-entry job queue has room and no issue
// request holds the front; an issue request holds the front while the PEC is run one
// byte per cycle, so the output side sets the sustained command rate. Frame bytes and
// verdicts leave in request order. Configure only while the engine is idle.
module daisy_chain_command_engine
  import dcce_pkg::*;
#(
  parameter int MAX_DEVICES = MAX_DEVICES_DEF
) (
  input  logic              clk,
  input  logic              rst,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,

  input  logic              in_valid,
  output logic              in_ready,
  input  logic              op,
  input  logic [1:0]        kind,
  input  logic [7:0]        reg_address,
  input  logic [15:0]       write_value,
  input  logic [4:0]        device_index,
  input  logic [7:0]        rx_byte,
  input  logic              rx_last,

  output logic              out_valid,
  input  logic              out_ready,
  output logic              result_kind,
  output logic [7:0]        tx_byte,
  output logic              last,
  output logic              pass,
  output logic              crc_error,
  output logic              echo_error,
  output logic              alive_error,
  output logic              length_error
);

  cfg_t       cfg;
  logic [1:0] reg_idx;
  logic       cfg_write;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  job_t       q_in;
  job_t       q_out;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_count    <= COUNT_W'(1);
      cfg.write_all_code  <= 8'd2;
      cfg.read_all_code   <= 8'd3;
      cfg.queue_load_code <= 8'd192;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_DEVICE_COUNT: cfg.device_count    <= pwdata[COUNT_W-1:0];
        REG_WRITE_ALL:    cfg.write_all_code  <= pwdata[BYTE_W-1:0];
        REG_READ_ALL:     cfg.read_all_code   <= pwdata[BYTE_W-1:0];
        REG_QUEUE_LOAD:   cfg.queue_load_code <= pwdata[BYTE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEVICE_COUNT: prdata = DATA_W'(cfg.device_count);
      REG_WRITE_ALL:    prdata = DATA_W'(cfg.write_all_code);
      REG_READ_ALL:     prdata = DATA_W'(cfg.read_all_code);
      REG_QUEUE_LOAD:   prdata = DATA_W'(cfg.queue_load_code);
    endcase
  end

  dcce_front #(
    .MAX_DEVICES(MAX_DEVICES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .kind        (kind),
    .reg_address (reg_address),
    .write_value (write_value),
    .device_index(device_index),
    .rx_byte     (rx_byte),
    .rx_last     (rx_last),
    .q_push      (q_push),
    .q_data      (q_in),
    .q_full      (q_full)
  );

  dcce_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_out),
    .empty    (q_empty)
  );

  dcce_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_pop       (q_pop),
    .q_data      (q_out),
    .q_empty     (q_empty),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .tx_byte     (tx_byte),
    .last        (last),
    .pass        (pass),
    .crc_error   (crc_error),
    .echo_error  (echo_error),
    .alive_error (alive_error),
    .length_error(length_error)
  );

endmodule

[design/dcce_queue.sv]
module dcce_queue
  import dcce_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t pop_data,
  output logic empty
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        slots[wr_ptr] <= push_data;
        wr_ptr        <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[design/dcce_front.sv]
module dcce_front
  import dcce_pkg::*;
#(
  parameter int MAX_DEVICES = MAX_DEVICES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [1:0]  kind,
  input  logic [7:0]  reg_address,
  input  logic [15:0] write_value,
  input  logic [4:0]  device_index,
  input  logic [7:0]  rx_byte,
  input  logic        rx_last,
  output logic        q_push,
  output job_t        q_data,
  input  logic        q_full
);

  typedef enum logic [1:0] {F_IDLE, F_CRC, F_PUSH} state_t;

  state_t              state;
  logic [BYTE_W-1:0]   echo [ECHO_DEPTH];
  logic [BYTE_W-1:0]   feed [3];
  logic [BYTE_W-1:0]   crc;
  logic [1:0]          crc_left;
  logic                frame_read;
  logic [LEN_W-1:0]    frame_len;
  logic [BYTE_W-1:0]   frame_ql;

  logic                pending_valid;
  logic [1:0]          pending_kind;
  logic [LEN_W-1:0]    rx_position;
  logic [LEN_W-1:0]    expected_length;
  logic [BYTE_W-1:0]   running_crc;
  logic [1:0]          error_flags;

  logic                in_acc;
  logic [COUNT_W-1:0]  chain_count;
  logic                cmd_read;
  logic [BYTE_W-1:0]   cmd_byte;
  logic [LEN_W-1:0]    cmd_len;

  logic [COUNT_W-1:0]  alive_exp;
  logic [BYTE_W-1:0]   echo_sel;
  logic                chk_set;
  logic                alive_set;
  logic                crc_upd;
  logic [LEN_W-1:0]    pos_next;
  logic [1:0]          flags_next;
  logic                len_err;
  logic                verdict_push;
  job_t                frame_job;
  job_t                verdict_job;

  assign in_ready = (state == F_IDLE) && !q_full;
  assign in_acc   = in_valid && in_ready;

  assign chain_count = (cfg.device_count > COUNT_W'(MAX_DEVICES)) ?
                       COUNT_W'(MAX_DEVICES) : cfg.device_count;

  // command byte and response length
  always_comb begin
    cmd_read = kind[1];
    unique case (kind)
      KIND_WRITE_ALL: cmd_byte = cfg.write_all_code;
      KIND_WRITE_DEV: cmd_byte = {device_index, ADDR_WRITE_TAG};
      KIND_READ_ALL:  cmd_byte = cfg.read_all_code;
      KIND_READ_DEV:  cmd_byte = {device_index, ADDR_READ_TAG};
    endcase
    unique case (kind)
      KIND_READ_ALL:  cmd_len = READ_BASE_LEN + LEN_W'({chain_count, 1'b0});
      KIND_READ_DEV:  cmd_len = READ_DEV_LEN;
      KIND_WRITE_ALL,
      KIND_WRITE_DEV: cmd_len = WRITE_RESP_LEN;
    endcase
  end

  // response byte checks
  always_comb begin
    alive_exp = pending_kind[0] ? COUNT_W'(1) : chain_count;
    unique case (rx_position[2:0])
      3'd0:    echo_sel = echo[0];
      3'd1:    echo_sel = echo[1];
      3'd2:    echo_sel = echo[2];
      3'd3:    echo_sel = echo[3];
      3'd4:    echo_sel = echo[4];
      default: echo_sel = '0;
    endcase
    chk_set   = 1'b0;
    alive_set = 1'b0;
    crc_upd   = 1'b0;
    if (rx_position < expected_length) begin
      if ({1'b0, rx_position} + 8'd1 == {1'b0, expected_length}) begin
        alive_set = (rx_byte != {2'b00, alive_exp});
      end else if (pending_kind[1]) begin
        if ({1'b0, rx_position} + 8'd2 == {1'b0, expected_length}) begin
          chk_set = (rx_byte != running_crc);
        end else begin
          crc_upd = 1'b1;
        end
      end else if (rx_position < LEN_W'(ECHO_DEPTH)) begin
        chk_set = (rx_byte != echo_sel);
      end
    end
    pos_next   = (rx_position < POS_MAX) ? rx_position + 1'b1 : rx_position;
    flags_next = error_flags | {alive_set, chk_set};
    len_err    = (pos_next != expected_length);
  end

  // outgoing jobs
  always_comb begin
    frame_job            = '0;
    frame_job.last_idx   = frame_read ? READ_LAST_IDX : WRITE_LAST_IDX;
    frame_job.frame[0]   = frame_ql;
    frame_job.frame[1]   = {1'b0, frame_len};
    frame_job.frame[2]   = echo[0];
    frame_job.frame[3]   = echo[1];
    frame_job.frame[4]   = echo[2];
    frame_job.frame[5]   = frame_read ? crc : echo[3];
    frame_job.frame[6]   = frame_read ? '0 : crc;
    frame_job.frame[7]   = '0;

    verdict_job            = '0;
    verdict_job.is_verdict = 1'b1;
    if (!pending_valid) begin
      verdict_job.length_error = 1'b1;
    end else begin
      verdict_job.length_error = len_err;
      verdict_job.alive_error  = flags_next[1];
      verdict_job.crc_error    = pending_kind[1] & flags_next[0];
      verdict_job.echo_error   = !pending_kind[1] & flags_next[0];
      verdict_job.pass         = !(len_err | flags_next[0] | flags_next[1]);
    end

    verdict_push = in_acc && (op == OP_RESPONSE) && (!pending_valid || rx_last);
    q_push       = verdict_push || ((state == F_PUSH) && !q_full);
    q_data       = verdict_push ? verdict_job : frame_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= F_IDLE;
      pending_valid   <= 1'b0;
      pending_kind    <= '0;
      rx_position     <= '0;
      expected_length <= '0;
      running_crc     <= '0;
      error_flags     <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_acc && op == OP_ISSUE) begin
            echo[0]    <= cmd_byte;
            echo[1]    <= reg_address;
            echo[2]    <= cmd_read ? '0 : write_value[7:0];
            echo[3]    <= cmd_read ? '0 : write_value[15:8];
            feed[0]    <= reg_address;
            feed[1]    <= cmd_read ? '0 : write_value[7:0];
            feed[2]    <= write_value[15:8];
            crc        <= pec_update('0, cmd_byte);
            crc_left   <= cmd_read ? 2'd2 : 2'd3;
            frame_read <= cmd_read;
            frame_len  <= cmd_len;
            frame_ql   <= cfg.queue_load_code;

            pending_valid   <= 1'b1;
            pending_kind    <= kind;
            rx_position     <= '0;
            expected_length <= cmd_len;
            running_crc     <= '0;
            error_flags     <= '0;
            state           <= F_CRC;
          end else if (in_acc && pending_valid) begin
            if (rx_last) begin
              pending_valid   <= 1'b0;
              pending_kind    <= '0;
              rx_position     <= '0;
              expected_length <= '0;
              running_crc     <= '0;
              error_flags     <= '0;
            end else begin
              rx_position <= pos_next;
              error_flags <= flags_next;
              if (crc_upd) begin
                running_crc <= pec_update(running_crc, rx_byte);
              end
            end
          end
        end
        F_CRC: begin
          // one PEC byte per cycle over the register and data bytes
          crc      <= pec_update(crc, feed[0]);
          feed[0]  <= feed[1];
          feed[1]  <= feed[2];
          crc_left <= crc_left - 1'b1;
          if (crc_left == 2'd1) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full) begin
            echo[4] <= crc;
            state   <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

[design/dcce_back.sv]
module dcce_back
  import dcce_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  output logic       q_pop,
  input  job_t       q_data,
  input  logic       q_empty,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       result_kind,
  output logic [7:0] tx_byte,
  output logic       last,
  output logic       pass,
  output logic       crc_error,
  output logic       echo_error,
  output logic       alive_error,
  output logic       length_error
);

  job_t              cur;
  logic              cur_valid;
  logic [FIDX_W-1:0] idx;
  logic              at_last;
  logic              out_acc;

  assign at_last   = cur.is_verdict || (idx == cur.last_idx);
  assign out_acc   = cur_valid && out_ready;
  assign q_pop     = !q_empty && (!cur_valid || (out_acc && at_last));
  assign out_valid = cur_valid;

  assign result_kind  = cur.is_verdict;
  assign tx_byte      = cur.is_verdict ? '0 : cur.frame[idx];
  assign last         = at_last;
  assign pass         = cur.pass;
  assign crc_error    = cur.crc_error;
  assign echo_error   = cur.echo_error;
  assign alive_error  = cur.alive_error;
  assign length_error = cur.length_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (q_pop) begin
      cur       <= q_data;
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (out_acc) begin
      // advance through the frame, drop the job after its last byte
      if (at_last) begin
        cur_valid <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule

[sim/daisy_chain_command_engine_tb.sv]
`timescale 1ns / 1ps

module daisy_chain_command_engine_tb;
  import dcce_pkg::*;

  localparam int CHAIN_MAX   = MAX_DEVICES_DEF;
  localparam int SETTLE      = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 10;

  typedef struct packed {
    logic       rkind;
    logic [7:0] tx;
    logic       lst;
    logic       ok;
    logic       crc_e;
    logic       echo_e;
    logic       alive_e;
    logic       len_e;
  } result_t;

  typedef enum int {
    RESP_GOOD,
    RESP_BAD_BODY,
    RESP_BAD_ALIVE,
    RESP_SHORT,
    RESP_LONG
  } resp_mode_e;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              op = 1'b0;
  logic [1:0]        kind = 2'd0;
  logic [7:0]        reg_address = 8'd0;
  logic [15:0]       write_value = 16'd0;
  logic [4:0]        device_index = 5'd0;
  logic [7:0]        rx_byte = 8'd0;
  logic              rx_last = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              result_kind;
  logic [7:0]        tx_byte;
  logic              last;
  logic              pass;
  logic              crc_error;
  logic              echo_error;
  logic              alive_error;
  logic              length_error;

  // predictor state
  cfg_t       engine_cfg;
  logic       cmd_pending;
  logic [1:0] cmd_kind;
  logic [7:0] echo_bytes [5];
  logic [6:0] rx_count;
  logic [6:0] resp_len;
  logic [7:0] rx_crc;
  logic [1:0] rx_flags;
  result_t    tx_and_verdict_q [$];

  int mismatch_count = 0;
  int items_sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int results_seen = 0;
  int pat_left = 0;
  int stall_mode = 0;
  logic [15:0] stall_mask = 16'hFFFF;

  daisy_chain_command_engine #(
    .MAX_DEVICES(CHAIN_MAX)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .kind(kind),
    .reg_address(reg_address),
    .write_value(write_value),
    .device_index(device_index),
    .rx_byte(rx_byte),
    .rx_last(rx_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result_kind(result_kind),
    .tx_byte(tx_byte),
    .last(last),
    .pass(pass),
    .crc_error(crc_error),
    .echo_error(echo_error),
    .alive_error(alive_error),
    .length_error(length_error)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    repeat (8) begin
      if (c[0]) c = (c >> 1) ^ 8'hB2;
      else c = c >> 1;
    end
    return c;
  endfunction

  function automatic int chain_count();
    if (int'(engine_cfg.device_count) > CHAIN_MAX) return CHAIN_MAX;
    return int'(engine_cfg.device_count);
  endfunction

  function automatic int alive_expected();
    return cmd_kind[0] ? 1 : chain_count();
  endfunction

  function automatic void queue_result(logic rk, logic [7:0] tx, logic lst, logic ok,
                                       logic ce, logic ee, logic ae, logic le);
    result_t r;
    r = {rk, tx, lst, ok, ce, ee, ae, le};
    tx_and_verdict_q.push_back(r);
  endfunction

  function automatic void predict_engine(logic o, logic [1:0] k, logic [7:0] ra,
                                         logic [15:0] wv, logic [4:0] di,
                                         logic [7:0] rb, logic rl);
    logic [7:0] frame [8];
    logic [7:0] cmd;
    logic [7:0] crc;
    int nb, len_v, p, i;
    logic rd, len_err;
    if (o == OP_ISSUE) begin
      rd = k[1];
      case (k)
        KIND_WRITE_ALL: cmd = engine_cfg.write_all_code;
        KIND_WRITE_DEV: cmd = {di, ADDR_WRITE_TAG};
        KIND_READ_ALL:  cmd = engine_cfg.read_all_code;
        default:        cmd = {di, ADDR_READ_TAG};
      endcase
      if (!rd) len_v = int'(WRITE_RESP_LEN);
      else if (k == KIND_READ_ALL) len_v = int'(READ_BASE_LEN) + 2 * chain_count();
      else len_v = int'(READ_DEV_LEN);
      frame[0] = engine_cfg.queue_load_code;
      frame[1] = 8'(len_v);
      frame[2] = cmd;
      frame[3] = ra;
      if (rd) begin
        frame[4] = 8'h00;
        nb = 3;
      end else begin
        frame[4] = wv[7:0];
        frame[5] = wv[15:8];
        nb = 4;
      end
      crc = 8'h00;
      for (i = 0; i < nb; i++) crc = crc8_step(crc, frame[2 + i]);
      frame[2 + nb] = crc;
      frame[3 + nb] = 8'h00;
      nb += 4;
      for (i = 0; i < 5; i++) echo_bytes[i] = frame[2 + i];
      cmd_kind = k;
      cmd_pending = 1'b1;
      rx_count = 7'd0;
      resp_len = 7'(len_v);
      rx_crc = 8'h00;
      rx_flags = 2'b00;
      for (i = 0; i < nb; i++)
        queue_result(1'b0, frame[i], i == nb - 1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
      return;
    end
    if (!cmd_pending) begin
      queue_result(1'b1, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
      return;
    end
    rd = cmd_kind[1];
    p = int'(rx_count);
    if (p < int'(resp_len)) begin
      if (p + 1 == int'(resp_len)) begin
        if (rb != 8'(alive_expected())) rx_flags[1] = 1'b1;
      end else if (rd) begin
        // PEC byte sits just before the alive counter
        if (p + 2 == int'(resp_len)) begin
          if (rb != rx_crc) rx_flags[0] = 1'b1;
        end else begin
          rx_crc = crc8_step(rx_crc, rb);
        end
      end else if (p < 5) begin
        if (rb != echo_bytes[p]) rx_flags[0] = 1'b1;
      end
    end
    if (p < int'(POS_MAX)) rx_count = 7'(p + 1);
    if (rl) begin
      len_err = (rx_count != resp_len);
      queue_result(1'b1, 8'h00, 1'b1, !(len_err | rx_flags[0] | rx_flags[1]),
                   rd & rx_flags[0], !rd & rx_flags[0], rx_flags[1], len_err);
      cmd_pending = 1'b0;
      cmd_kind = 2'd0;
      rx_count = 7'd0;
      resp_len = 7'd0;
      rx_crc = 8'h00;
      rx_flags = 2'b00;
    end
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("%0t ns: mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, int idx, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h", idx, name, got, want));
  endtask

  task automatic push_request(logic o, logic [1:0] k, logic [7:0] ra, logic [15:0] wv,
                              logic [4:0] di, logic [7:0] rb, logic rl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    op <= o;
    kind <= k;
    reg_address <= ra;
    write_value <= wv;
    device_index <= di;
    rx_byte <= rb;
    rx_last <= rl;
    do @(posedge clk); while (!in_ready);
    predict_engine(o, k, ra, wv, di, rb, rl);
    items_sent++;
  endtask

  task automatic issue_cmd(logic [1:0] k, logic [7:0] ra, logic [15:0] wv, logic [4:0] di);
    push_request(OP_ISSUE, k, ra, wv, di, 8'($urandom), 1'($urandom));
  endtask

  task automatic issue_random_cmd();
    issue_cmd(2'($urandom), 8'($urandom), 16'($urandom), 5'($urandom));
  endtask

  task automatic send_rx(logic [7:0] b, logic l);
    push_request(OP_RESPONSE, 2'($urandom), 8'($urandom), 16'($urandom), 5'($urandom), b, l);
  endtask

  // Build the response the chain would return for the pending command, then damage it unless the mode is RESP_GOOD.
  task automatic answer_pending(resp_mode_e mode, int extra);
    logic [7:0] bytes_q [$];
    logic [7:0] crc, b;
    int n, p;
    if (!cmd_pending) begin
      send_rx(8'($urandom), 1'b1);
      return;
    end
    n = int'(resp_len);
    crc = 8'h00;
    for (p = 0; p < n; p++) begin
      if (p == n - 1) begin
        b = 8'(alive_expected());
      end else if (cmd_kind[1]) begin
        if (p == n - 2) begin
          b = crc;
        end else begin
          b = 8'($urandom);
          crc = crc8_step(crc, b);
        end
      end else begin
        b = echo_bytes[p];
      end
      bytes_q.push_back(b);
    end
    case (mode)
      RESP_BAD_BODY: begin
        p = $urandom_range(0, n - 2);
        bytes_q[p] = bytes_q[p] ^ (8'h01 << $urandom_range(0, 7));
      end
      RESP_BAD_ALIVE: begin
        bytes_q[n - 1] = bytes_q[n - 1] ^ 8'($urandom_range(1, 255));
      end
      RESP_SHORT: begin
        repeat ($urandom_range(1, n - 1)) void'(bytes_q.pop_back());
      end
      RESP_LONG: begin
        repeat (extra) bytes_q.push_back(8'($urandom));
      end
      default: begin
      end
    endcase
    for (p = 0; p < bytes_q.size(); p++) send_rx(bytes_q[p], p == bytes_q.size() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tx_and_verdict_q.size() != 0) @(posedge clk);
    // let a response still being absorbed finish before anything else happens
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_DEVICE_COUNT: engine_cfg.device_count = value[5:0];
      REG_WRITE_ALL:    engine_cfg.write_all_code = value;
      REG_READ_ALL:     engine_cfg.read_all_code = value;
      default:          engine_cfg.queue_load_code = value;
    endcase
  endtask

  task automatic test_stray_byte();
    send_rx(8'hFF, 1'b0);
    send_rx(8'h00, 1'b1);
  endtask

  task automatic test_replace_pending();
    issue_cmd(KIND_WRITE_ALL, 8'hFF, 16'hFFFF, 5'd31);
    send_rx(8'($urandom), 1'b0);
    issue_cmd(KIND_WRITE_DEV, 8'h00, 16'h0000, 5'd31);
    answer_pending(RESP_GOOD, 0);
  endtask

  task automatic test_short_response();
    issue_cmd(KIND_READ_DEV, 8'hFF, 16'hFFFF, 5'd0);
    answer_pending(RESP_SHORT, 0);
  endtask

  task automatic test_long_response();
    issue_cmd(KIND_READ_ALL, 8'h00, 16'h0000, 5'd0);
    answer_pending(RESP_LONG, 2);
  endtask

  task automatic test_config_extremes();
    wait_drained();
    write_reg(REG_DEVICE_COUNT, 8'd0);
    write_reg(REG_WRITE_ALL, 8'h00);
    write_reg(REG_READ_ALL, 8'hFF);
    write_reg(REG_QUEUE_LOAD, 8'h00);
    issue_cmd(KIND_WRITE_ALL, 8'h5A, 16'hA55A, 5'd0);
    answer_pending(RESP_GOOD, 0);
    issue_cmd(KIND_READ_ALL, 8'hA5, 16'h5AA5, 5'd31);
    answer_pending(RESP_GOOD, 0);
    wait_drained();
    write_reg(REG_DEVICE_COUNT, 8'(CHAIN_MAX));
    write_reg(REG_WRITE_ALL, 8'hFF);
    write_reg(REG_READ_ALL, 8'h00);
    write_reg(REG_QUEUE_LOAD, 8'hFF);
    issue_cmd(KIND_WRITE_ALL, 8'($urandom), 16'($urandom), 5'($urandom));
    answer_pending(RESP_GOOD, 0);
  endtask

  task automatic test_count_clamp();
    wait_drained();
    write_reg(REG_DEVICE_COUNT, 8'd63);
    issue_cmd(KIND_WRITE_ALL, 8'($urandom), 16'($urandom), 5'($urandom));
    answer_pending(RESP_GOOD, 0);
    // clamped length shows in the frame; cut the response short
    issue_cmd(KIND_READ_ALL, 8'($urandom), 16'($urandom), 5'($urandom));
    repeat (3) send_rx(8'($urandom), 1'b0);
    send_rx(8'($urandom), 1'b1);
  endtask

  task automatic test_random_traffic();
    int phase, start, r;
    for (phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0:       write_reg(REG_DEVICE_COUNT, 8'd1);
        1:       write_reg(REG_DEVICE_COUNT, 8'd2);
        2:       write_reg(REG_DEVICE_COUNT, 8'($urandom_range(0, 4)));
        default: write_reg(REG_DEVICE_COUNT, 8'($urandom_range(3, 8)));
      endcase
      write_reg(REG_WRITE_ALL, 8'($urandom));
      write_reg(REG_READ_ALL, 8'($urandom));
      write_reg(REG_QUEUE_LOAD, 8'($urandom));
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          issue_random_cmd();
          if ($urandom_range(0, 1) == 0) answer_pending(RESP_GOOD, 0);
          else answer_pending(resp_mode_e'($urandom_range(1, 4)), $urandom_range(1, 4));
        end else if (r < 70) begin
          issue_random_cmd();
          repeat ($urandom_range(0, 3)) send_rx(8'($urandom), 1'b0);
          issue_random_cmd();
          answer_pending(RESP_GOOD, 0);
        end else if (r < 80) begin
          repeat ($urandom_range(1, 3)) send_rx(8'($urandom), 1'($urandom));
        end else if (r < 88) begin
          issue_random_cmd();
        end else if (r < 93) begin
          wait_drained();
        end else begin
          send_rx(8'($urandom), 1'b1);
        end
      end
    end
  endtask

  // receiver: ready pattern changes when its random run length runs out
  always @(posedge clk) begin
    if (pat_left == 0) begin
      pat_left = $urandom_range(16, 96);
      stall_mode = $urandom_range(0, 2);
      stall_mask = 16'($urandom);
    end
    pat_left--;
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= stall_mask[pat_left & 15];
      default: out_ready <= 1'($urandom);
    endcase
  end

  always @(posedge clk) begin : result_check
    result_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = {result_kind, tx_byte, last, pass, crc_error, echo_error, alive_error,
             length_error};
      // give the request accepted on this edge time to be predicted
      #1;
      results_seen++;
      if (tx_and_verdict_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected: %h",
                                  results_seen, got));
      end else begin
        want = tx_and_verdict_q.pop_front();
        check_field("result_kind", results_seen, 8'(got.rkind), 8'(want.rkind));
        check_field("tx_byte", results_seen, got.tx, want.tx);
        check_field("last", results_seen, 8'(got.lst), 8'(want.lst));
        check_field("pass", results_seen, 8'(got.ok), 8'(want.ok));
        check_field("crc_error", results_seen, 8'(got.crc_e), 8'(want.crc_e));
        check_field("echo_error", results_seen, 8'(got.echo_e), 8'(want.echo_e));
        check_field("alive_error", results_seen, 8'(got.alive_e), 8'(want.alive_e));
        check_field("length_error", results_seen, 8'(got.len_e), 8'(want.len_e));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results outstanding", idle_cycles,
               tx_and_verdict_q.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    engine_cfg.device_count = 6'd1;
    engine_cfg.write_all_code = 8'd2;
    engine_cfg.read_all_code = 8'd3;
    engine_cfg.queue_load_code = 8'd192;
    cmd_pending = 1'b0;
    cmd_kind = 2'd0;
    rx_count = 7'd0;
    resp_len = 7'd0;
    rx_crc = 8'h00;
    rx_flags = 2'b00;
    for (int i = 0; i < 5; i++) echo_bytes[i] = 8'h00;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_stray_byte();
    test_replace_pending();
    test_short_response();
    test_long_response();
    test_config_extremes();
    test_count_clamp();
    test_random_traffic();
    wait_drained();
    if (mismatch_count == 0 && tx_and_verdict_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[daisy_chain_command_engine.f]
design/dcce_pkg.sv
design/dcce_queue.sv
design/dcce_front.sv
design/dcce_back.sv
design/daisy_chain_command_engine.sv
sim/daisy_chain_command_engine_tb.sv
